[hdl/krk_pkg.sv]
// Shared constants and control types for the Kruskal spanning-forest block.
package krk_pkg;

   localparam int DEF_MAX_VERTICES = 16;
   localparam int DEF_MAX_EDGES    = 32;
   localparam int WEIGHT_W         = 16;

   typedef struct packed {
      logic ins;
      logic pop;
      logic clr;
   } sort_ctl_type;

   typedef struct packed {
      logic init;
      logic merge;
   } vtx_ctl_type;

endpackage

[hdl/krk_sort_cell.sv]
// One cell of the sorted edge chain: holds one edge and hands it to a neighbor.
module krk_sort_cell
   import krk_pkg::*;
#(
   parameter int VW = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  sort_ctl_type        ctl,
   input  logic [VW-1:0]       new_from,
   input  logic [VW-1:0]       new_to,
   input  logic [WEIGHT_W-1:0] new_weight,
   input  logic [VW-1:0]       prev_from,
   input  logic [VW-1:0]       prev_to,
   input  logic [WEIGHT_W-1:0] prev_weight,
   input  logic                prev_take,
   input  logic                prev_valid,
   input  logic [VW-1:0]       next_from,
   input  logic [VW-1:0]       next_to,
   input  logic [WEIGHT_W-1:0] next_weight,
   input  logic                next_valid,
   output logic [VW-1:0]       cell_from,
   output logic [VW-1:0]       cell_to,
   output logic [WEIGHT_W-1:0] cell_weight,
   output logic                cell_valid,
   output logic                take
);

   logic [VW-1:0]       from_ff, to_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                valid_ff;

   // A new item lands in front of the first stored item that is strictly
   // heavier, so items of equal weight keep their load order. An empty cell
   // takes only when it is the first empty one, right behind the stored items.
   assign take = ctl.ins && (valid_ff ? ($signed(weight_ff) > $signed(new_weight))
                                      : prev_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clr) begin
         valid_ff <= 1'b0;
      end else if (ctl.pop) begin
         valid_ff <= next_valid;
      end else if (take) begin
         valid_ff <= 1'b1;
      end
      if (ctl.pop) begin
         from_ff   <= next_from;
         to_ff     <= next_to;
         weight_ff <= next_weight;
      end else if (take) begin
         if (prev_take) begin
            from_ff   <= prev_from;
            to_ff     <= prev_to;
            weight_ff <= prev_weight;
         end else begin
            from_ff   <= new_from;
            to_ff     <= new_to;
            weight_ff <= new_weight;
         end
      end
   end

   assign cell_from   = from_ff;
   assign cell_to     = to_ff;
   assign cell_weight = weight_ff;
   assign cell_valid  = valid_ff;

endmodule

[hdl/krk_vertex_cell.sv]
// One vertex cell: holds the component label of its vertex.
module krk_vertex_cell
   import krk_pkg::*;
#(
   parameter int VW  = 4,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  vtx_ctl_type   ctl,
   input  logic [VW-1:0] probe_a,
   input  logic [VW-1:0] probe_b,
   input  logic [VW-1:0] join_a,
   input  logic [VW-1:0] join_b,
   output logic [VW-1:0] label_a,
   output logic [VW-1:0] label_b
);

   localparam logic [VW-1:0] OwnIdx = VW'(IDX);

   logic [VW-1:0] label_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         label_ff <= OwnIdx;
      end else if (ctl.merge && (label_ff == join_b)) begin
         label_ff <= join_a;
      end
   end

   // Only the addressed cell drives a nonzero value into the OR trees.
   assign label_a = (probe_a == OwnIdx) ? label_ff : '0;
   assign label_b = (probe_b == OwnIdx) ? label_ff : '0;

endmodule

[hdl/kruskal_minimum_spanning_tree.sv]
// Top level of the Kruskal spanning-forest block: edge chain, vertex cells, scan control.
// Edges are taken one item per cycle while loading (not during a scan) and sorted
// on arrival by a chain of cells (MAX_EDGES cells, stable for equal weights); a full
// chain drops further edges, as do edges with an endpoint at or above vertex_count.
// The item marked tlast starts the scan: each stored edge goes through a head pop
// with label lookup, then a compare and merge across the vertex cells, until the
// chain is empty or MAX_VERTICES-1 tree edges are found; a flush step closes the run.
// Merge and flush may wait on an output stall. Results come out in weight order; a run
// without any tree edge gives one item with tuser set.
module kruskal_minimum_spanning_tree
   import krk_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   localparam int VW  = $clog2(MAX_VERTICES),
   localparam int CW  = $clog2(MAX_VERTICES + 1),
   localparam int IW  = ((2 * VW + WEIGHT_W + 7) / 8) * 8,
   localparam int OW  = ((3 * VW + WEIGHT_W + 7) / 8) * 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [IW-1:0] req_tdata,  // edge_from, edge_to, edge_weight, zero fill
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [OW-1:0] rsp_tdata,  // tree_from, tree_to, tree_weight, tree_index, zero fill
   output logic          rsp_tuser,  // empty_tree
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [CW-1:0] csr_data
);

   localparam logic [CW-1:0] MaxV       = CW'(MAX_VERTICES);
   localparam logic [VW-1:0] MaxResults = VW'(MAX_VERTICES - 1);

   typedef enum logic [1:0] {S_LOAD, S_LOOK, S_JOIN, S_FLUSH} state_type;

   state_type state_ff;
   logic [CW-1:0] vcount_ff;

   logic [VW-1:0]       e_from_ff, e_to_ff, la_ff, lb_ff;
   logic [WEIGHT_W-1:0] e_weight_ff;
   logic                e_ok_ff;
   logic [VW-1:0]       p_from_ff, p_to_ff, p_idx_ff;
   logic [WEIGHT_W-1:0] p_weight_ff;
   logic                p_valid_ff;
   logic [VW-1:0]       cnt_ff;

   logic                out_valid_ff, out_empty_ff, out_last_ff;
   logic [VW-1:0]       out_from_ff, out_to_ff, out_idx_ff;
   logic [WEIGHT_W-1:0] out_weight_ff;

   logic [VW-1:0]       in_from, in_to;
   logic [WEIGHT_W-1:0] in_weight;
   logic [CW-1:0]       nv;
   logic                req_acc, out_free, in_ok;
   sort_ctl_type        sctl;
   vtx_ctl_type         vctl;

   logic [VW-1:0]       c_from   [MAX_EDGES];
   logic [VW-1:0]       c_to     [MAX_EDGES];
   logic [WEIGHT_W-1:0] c_weight [MAX_EDGES];
   logic                c_valid  [MAX_EDGES];
   logic                c_take   [MAX_EDGES];
   logic [VW-1:0]       v_la     [MAX_VERTICES];
   logic [VW-1:0]       v_lb     [MAX_VERTICES];
   logic [VW-1:0]       la, lb;
   logic                head_ok;

   assign in_from   = req_tdata[VW-1:0];
   assign in_to     = req_tdata[2*VW-1:VW];
   assign in_weight = req_tdata[2*VW+WEIGHT_W-1:2*VW];

   assign nv       = (vcount_ff > MaxV) ? MaxV : vcount_ff;
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_ok      = (CW'(in_from) < nv) && (CW'(in_to) < nv);

   assign head_ok = (CW'(c_from[0]) < nv) && (CW'(c_to[0]) < nv);

   always_comb begin
      sctl.ins = req_acc && in_ok && !c_valid[MAX_EDGES-1];
      sctl.pop = (state_ff == S_LOOK) && c_valid[0] && (cnt_ff != MaxResults);
      sctl.clr = (state_ff == S_FLUSH) && out_free;
      vctl.init = req_acc && req_tlast;
      vctl.merge = (state_ff == S_JOIN) && e_ok_ff && (la_ff != lb_ff)
                   && (!p_valid_ff || out_free);
   end

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_chain
      logic [VW-1:0]       pf, pt, nf, nt;
      logic [WEIGHT_W-1:0] pw, nw;
      logic                ptk, pv, nvld;
      if (i == 0) begin : g_head
         assign pf = '0;
         assign pt = '0;
         assign pw = '0;
         assign ptk = 1'b0;
         assign pv = 1'b1;
      end else begin : g_body
         assign pf = c_from[i-1];
         assign pt = c_to[i-1];
         assign pw = c_weight[i-1];
         assign ptk = c_take[i-1];
         assign pv = c_valid[i-1];
      end
      if (i == MAX_EDGES - 1) begin : g_tail
         assign nf = '0;
         assign nt = '0;
         assign nw = '0;
         assign nvld = 1'b0;
      end else begin : g_mid
         assign nf = c_from[i+1];
         assign nt = c_to[i+1];
         assign nw = c_weight[i+1];
         assign nvld = c_valid[i+1];
      end
      krk_sort_cell #(.VW(VW)) u_cell (
         .clock(clock), .reset(reset), .ctl(sctl),
         .new_from(in_from), .new_to(in_to), .new_weight(in_weight),
         .prev_from(pf), .prev_to(pt), .prev_weight(pw), .prev_take(ptk),
         .prev_valid(pv),
         .next_from(nf), .next_to(nt), .next_weight(nw), .next_valid(nvld),
         .cell_from(c_from[i]), .cell_to(c_to[i]), .cell_weight(c_weight[i]),
         .cell_valid(c_valid[i]), .take(c_take[i])
      );
   end

   for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_vtx
      krk_vertex_cell #(.VW(VW), .IDX(v)) u_vtx (
         .clock(clock), .reset(reset), .ctl(vctl),
         .probe_a(c_from[0]), .probe_b(c_to[0]),
         .join_a(la_ff), .join_b(lb_ff),
         .label_a(v_la[v]), .label_b(v_lb[v])
      );
   end

   always_comb begin
      la = '0;
      lb = '0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
         la = la | v_la[v];
         lb = lb | v_lb[v];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         vcount_ff    <= MaxV;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         e_ok_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            vcount_ff <= csr_data;
         end
         if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_acc && req_tlast) begin
                  cnt_ff     <= '0;
                  p_valid_ff <= 1'b0;
                  state_ff   <= S_LOOK;
               end
            end
            S_LOOK: begin
               if (sctl.pop) begin
                  e_from_ff   <= c_from[0];
                  e_to_ff     <= c_to[0];
                  e_weight_ff <= c_weight[0];
                  e_ok_ff     <= head_ok;
                  la_ff       <= la;
                  lb_ff       <= lb;
                  state_ff    <= S_JOIN;
               end else begin
                  state_ff <= S_FLUSH;
               end
            end
            S_JOIN: begin
               if (!(e_ok_ff && (la_ff != lb_ff))) begin
                  state_ff <= S_LOOK;
               end else if (vctl.merge) begin
                  // The previous tree edge is sent now that a later one exists.
                  if (p_valid_ff) begin
                     out_valid_ff  <= 1'b1;
                     out_from_ff   <= p_from_ff;
                     out_to_ff     <= p_to_ff;
                     out_weight_ff <= p_weight_ff;
                     out_idx_ff    <= p_idx_ff;
                     out_empty_ff  <= 1'b0;
                     out_last_ff   <= 1'b0;
                  end
                  p_valid_ff  <= 1'b1;
                  p_from_ff   <= e_from_ff;
                  p_to_ff     <= e_to_ff;
                  p_weight_ff <= e_weight_ff;
                  p_idx_ff    <= cnt_ff;
                  cnt_ff      <= cnt_ff + 1'b1;
                  state_ff    <= S_LOOK;
               end
            end
            S_FLUSH: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_last_ff   <= 1'b1;
                  out_empty_ff  <= !p_valid_ff;
                  out_from_ff   <= p_valid_ff ? p_from_ff : '0;
                  out_to_ff     <= p_valid_ff ? p_to_ff : '0;
                  out_weight_ff <= p_valid_ff ? p_weight_ff : '0;
                  out_idx_ff    <= p_valid_ff ? p_idx_ff : '0;
                  p_valid_ff    <= 1'b0;
                  state_ff      <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_empty_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = OW'({out_idx_ff, out_weight_ff, out_to_ff, out_from_ff});

endmodule

[hdl/krk_checker.sv]
// Port-level checks for the Kruskal spanning-forest block, bound to the top level.
module krk_checker
   import krk_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int OW = ((3 * VW + WEIGHT_W + 7) / 8) * 8
) (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          req_tlast,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [OW-1:0] rsp_tdata,
   input logic          rsp_tuser,
   input logic          rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty result item is not a lone zero item");

   a_no_load_in_run: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("new item taken right after the last edge");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item shown after reset");

endmodule

bind kruskal_minimum_spanning_tree krk_checker #(.MAX_VERTICES(MAX_VERTICES)) u_krk_checker (.*);
